// ----- hdl/emrd_pkg.sv -----
// Package for the extent map range delete unit.
// Holds the entry and cell command types, command/status codes and sizes.
// No dependencies.
package emrd_pkg;

    localparam int MAX_EXTENTS_DEF = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

    // input commands
    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;  // unused, answered with a miss

    // result status
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // cell operations
    localparam logic [2:0] K_NONE = 3'd0;  // hold
    localparam logic [2:0] K_WSB  = 3'd1;  // write first offset and block at target
    localparam logic [2:0] K_WALL = 3'd2;  // write whole entry at target
    localparam logic [2:0] K_INS  = 3'd3;  // open a slot at the selected cell
    localparam logic [2:0] K_DEL  = 3'd4;  // close the slot at the selected cell

    typedef struct packed {
        logic [31:0] ext_first;
        logic [31:0] ext_last;
        logic [31:0] ext_block;
    } t_entry;

    typedef struct packed {
        logic [2:0] kind;
        logic       tgt_prev;   // target the cell left of the selected one
        t_entry     ent;
    } t_cell_cmd;

    // first member sits in the high bits, so fields are listed top down
    typedef struct packed {
        logic [32:0] freed_length;
        logic [31:0] freed_block;
        logic [31:0] found_block;
        logic [31:0] found_end;
        logic [31:0] found_start;
        logic [1:0]  status;
    } t_out_word;

endpackage

// ----- hdl/emrd_cell.sv -----
// One slot of the sorted extent row: holds an entry, compares it with the
// broadcast key and shifts left or right with its neighbors.
// Depends on emrd_pkg.
module emrd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_find,
    input  logic               i_valid,
    input  logic [31:0]        i_key,
    input  logic [31:0]        i_key2,
    input  logic               i_left_after,
    input  emrd_pkg::t_entry   i_left,
    input  emrd_pkg::t_entry   i_right,
    input  logic               i_right_sel,
    input  emrd_pkg::t_cell_cmd i_cmd,
    output emrd_pkg::t_entry   o_entry,
    output emrd_pkg::t_entry   o_sel_entry,
    output logic               o_after,
    output logic               o_sel,
    output logic               o_eq
);

    emrd_pkg::t_entry r_entry;
    emrd_pkg::t_entry n_entry;
    logic             r_after;
    logic             r_eq;
    logic             w_sel;
    logic             w_tgt;

    // ends are sorted, so "after" is a step function along the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after <= 1'b0;
            r_eq    <= 1'b0;
        end else if (i_find) begin
            r_after <= !(i_valid && (r_entry.ext_last < i_key));
            r_eq    <= i_valid && (r_entry.ext_last == i_key2);
        end
    end

    assign w_sel = r_after && !i_left_after;
    assign w_tgt = i_cmd.tgt_prev ? i_right_sel : w_sel;

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.kind)
            emrd_pkg::K_NONE: begin
            end
            emrd_pkg::K_WSB: begin
                if (w_tgt) begin
                    n_entry.ext_first = i_cmd.ent.ext_first;
                    n_entry.ext_block = i_cmd.ent.ext_block;
                end
            end
            emrd_pkg::K_WALL: begin
                if (w_tgt) n_entry = i_cmd.ent;
            end
            emrd_pkg::K_INS: begin
                if (w_sel) n_entry = i_cmd.ent;
                else if (r_after) n_entry = i_left;
            end
            emrd_pkg::K_DEL: begin
                if (r_after) n_entry = i_right;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry     = r_entry;
    assign o_sel_entry = (w_sel && i_valid) ? r_entry : '0;
    assign o_after     = r_after;
    assign o_sel       = w_sel;
    assign o_eq        = r_eq;

endmodule

// ----- hdl/extent_map_range_delete_unit.sv -----
// A result word is loaded in the decide step, after the find and select steps. A new command
// is taken only from idle, once the last one is done; insert adds two row update steps.
// Delete: each freed piece runs find / select / decide and two row update steps; each
// piece word leaves at the next decide, the final one from a flush step or from the decide
// that finds no more overlap. A stalled output holds decide and flush. One word at a time.
// Synchronous active-low reset empties the table (count to zero); entry storage is not cleared.
module extent_map_range_delete_unit #(
    parameter int MAX_EXTENTS = emrd_pkg::MAX_EXTENTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // command[1:0], first_offset[33:2], last_offset[65:34], block_number[97:66]
    input  logic [103:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // status[1:0], found_start[33:2], found_end[65:34], found_block[97:66],
    // freed_block[129:98], freed_length[162:130]
    output logic [167:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast
);

    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int RW = emrd_pkg::RES_CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_U1    = 3'd4;
    localparam logic [2:0] S_U2    = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_next, n_next;
    logic [1:0]  r_cmd, n_cmd;
    logic [31:0] r_a, n_a, r_b, n_b, r_blk, n_blk;
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_s, n_s, r_e, n_e, r_k, n_k;
    logic        r_hit, n_hit, r_eq, n_eq;
    logic        r_pend_v, n_pend_v;
    logic [1:0]  r_pend_status, n_pend_status;
    logic [31:0] r_pend_block, n_pend_block;
    logic [32:0] r_pend_len, n_pend_len;
    logic [RW-1:0] r_n, n_n;
    emrd_pkg::t_cell_cmd r_cmd1, n_cmd1, r_cmd2, n_cmd2;
    logic        r_out_valid, n_out_valid;
    emrd_pkg::t_out_word r_out_word, n_out_word;
    logic        r_out_last, n_out_last;

    emrd_pkg::t_entry    w_entry [MAX_EXTENTS];
    emrd_pkg::t_entry    w_sel_entry [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] w_after, w_sel, w_eq, w_valid;
    emrd_pkg::t_cell_cmd w_cell_cmd;
    logic [31:0]         w_key, w_key2;
    logic                w_find;
    emrd_pkg::t_entry    w_pick;

    assign w_find = (r_state == S_FIND);
    assign w_key  = (r_cmd == emrd_pkg::CMD_INSERT) ? r_b : r_a;
    assign w_key2 = (r_cmd == emrd_pkg::CMD_INSERT) ? r_b : (r_a - 32'd1);

    always_comb begin
        w_cell_cmd = '0;
        if (r_state == S_U1) w_cell_cmd = r_cmd1;
        else if (r_state == S_U2) w_cell_cmd = r_cmd2;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EXTENTS; gi++) begin : g_cell
            logic             w_la;
            emrd_pkg::t_entry w_l;
            emrd_pkg::t_entry w_r;
            logic             w_rs;
            assign w_valid[gi] = (r_count > CW'(gi));
            if (gi == 0) begin : g_first
                assign w_la = 1'b0;
                assign w_l  = '0;
            end else begin : g_mid
                assign w_la = w_after[gi-1];
                assign w_l  = w_entry[gi-1];
            end
            if (gi == MAX_EXTENTS - 1) begin : g_end
                assign w_r  = w_entry[gi];
                assign w_rs = 1'b0;
            end else begin : g_nend
                assign w_r  = w_entry[gi+1];
                assign w_rs = w_sel[gi+1];
            end
            emrd_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_find       (w_find),
                .i_valid      (w_valid[gi]),
                .i_key        (w_key),
                .i_key2       (w_key2),
                .i_left_after (w_la),
                .i_left       (w_l),
                .i_right      (w_r),
                .i_right_sel  (w_rs),
                .i_cmd        (w_cell_cmd),
                .o_entry      (w_entry[gi]),
                .o_sel_entry  (w_sel_entry[gi]),
                .o_after      (w_after[gi]),
                .o_sel        (w_sel[gi]),
                .o_eq         (w_eq[gi])
            );
        end
    endgenerate

    always_comb begin
        w_pick = '0;
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            w_pick = w_pick | w_sel_entry[i];
        end
    end

    // delete piece arithmetic
    logic        w_lo, w_hi, w_dhit, w_room, w_full;
    logic [31:0] w_ms, w_me, w_tail_blk, w_trim_blk;
    logic [32:0] w_len;
    logic        w_can_load;

    assign w_lo       = (r_s >= r_a);
    assign w_hi       = (r_e <= r_b);
    assign w_ms       = w_lo ? r_s : r_a;
    assign w_me       = w_hi ? r_e : r_b;
    assign w_len      = {1'b0, w_me} - {1'b0, w_ms} + 33'd1;
    assign w_tail_blk = r_k + (r_a - r_s);
    assign w_trim_blk = r_k + (r_b - r_s + 32'd1);
    assign w_dhit     = r_hit && (r_s <= r_b);
    assign w_full     = (r_count == CW'(MAX_EXTENTS));
    assign w_room     = r_eq || !w_full;
    assign w_can_load = !r_out_valid || i_m_axis_tready;

    always_comb begin
        logic fin;
        n_state = r_state;  n_next = r_next;  n_cmd = r_cmd;
        n_a = r_a;  n_b = r_b;  n_blk = r_blk;  n_count = r_count;
        n_s = r_s;  n_e = r_e;  n_k = r_k;  n_hit = r_hit;  n_eq = r_eq;
        n_pend_v = r_pend_v;  n_pend_status = r_pend_status;
        n_pend_block = r_pend_block;  n_pend_len = r_pend_len;
        n_n = r_n;  n_cmd1 = r_cmd1;  n_cmd2 = r_cmd2;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_word = r_out_word;  n_out_last = r_out_last;
        fin = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_cmd    = i_s_axis_tdata[1:0];
                    n_a      = i_s_axis_tdata[33:2];
                    n_b      = i_s_axis_tdata[65:34];
                    n_blk    = i_s_axis_tdata[97:66];
                    n_pend_v = 1'b0;
                    n_n      = '0;
                    n_state  = S_FIND;
                end
            end
            S_FIND: n_state = S_SEL;
            S_SEL: begin
                n_s     = w_pick.ext_first;
                n_e     = w_pick.ext_last;
                n_k     = w_pick.ext_block;
                n_hit   = |(w_sel & w_valid);
                n_eq    = |w_eq;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (w_can_load) begin
                    n_cmd1 = '0;
                    n_cmd2 = '0;
                    n_out_word = '0;
                    n_out_valid = 1'b1;
                    n_out_last = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_cmd)
                        emrd_pkg::CMD_SEARCH: begin
                            if (!r_hit) begin
                                n_out_word.status = emrd_pkg::ST_NONE;
                            end else begin
                                n_out_word.status = (r_a >= r_s) ? emrd_pkg::ST_OK
                                                                 : emrd_pkg::ST_MISS;
                                n_out_word.found_start = r_s;
                                n_out_word.found_end   = r_e;
                                n_out_word.found_block = r_k;
                            end
                        end
                        emrd_pkg::CMD_INSERT: begin
                            n_next  = S_IDLE;
                            n_state = S_U1;
                            n_cmd1.ent = '{ext_first: r_a, ext_last: r_b, ext_block: r_blk};
                            if (r_a > r_b) begin
                                n_out_word.status = emrd_pkg::ST_MISS;
                            end else if (r_eq) begin
                                n_out_word.status = emrd_pkg::ST_OK;
                                n_cmd1.kind = emrd_pkg::K_WSB;
                            end else if (w_full) begin
                                n_out_word.status = emrd_pkg::ST_FULL;
                            end else begin
                                n_out_word.status = emrd_pkg::ST_OK;
                                n_cmd1.kind = emrd_pkg::K_INS;
                            end
                        end
                        emrd_pkg::CMD_DELETE: begin
                            if ((r_a > r_b) || !w_dhit) begin
                                if (r_pend_v) begin
                                    n_out_word.status       = r_pend_status;
                                    n_out_word.freed_block  = r_pend_block;
                                    n_out_word.freed_length = r_pend_len;
                                end else begin
                                    n_out_word.status = emrd_pkg::ST_MISS;
                                end
                                n_pend_v = 1'b0;
                            end else begin
                                n_out_valid = r_pend_v;
                                n_out_last  = 1'b0;
                                n_out_word.status       = r_pend_status;
                                n_out_word.freed_block  = r_pend_block;
                                n_out_word.freed_length = r_pend_len;
                                n_pend_v      = 1'b1;
                                n_pend_status = emrd_pkg::ST_OK;
                                n_pend_len    = w_len;
                                n_n           = r_n + RW'(1);
                                if (w_lo && w_hi) begin
                                    n_pend_block = r_k;
                                    n_cmd1.kind  = emrd_pkg::K_DEL;
                                end else if (w_lo) begin
                                    n_pend_block = r_k;
                                    n_cmd1.kind  = emrd_pkg::K_WSB;
                                    n_cmd1.ent.ext_first = r_b + 32'd1;
                                    n_cmd1.ent.ext_block = w_trim_blk;
                                    fin = 1'b1;
                                end else if (w_hi) begin
                                    n_pend_block = w_tail_blk;
                                    if (r_eq) begin
                                        n_cmd1.kind     = emrd_pkg::K_WSB;
                                        n_cmd1.tgt_prev = 1'b1;
                                        n_cmd1.ent.ext_first = r_s;
                                        n_cmd1.ent.ext_block = r_k;
                                        n_cmd2.kind     = emrd_pkg::K_DEL;
                                    end else begin
                                        n_cmd1.kind = emrd_pkg::K_WALL;
                                        n_cmd1.ent  = '{ext_first: r_s,
                                                        ext_last: r_a - 32'd1,
                                                        ext_block: r_k};
                                    end
                                end else if (!w_room) begin
                                    n_pend_status = emrd_pkg::ST_FULL;
                                    n_pend_block  = '0;
                                    n_pend_len    = '0;
                                    fin = 1'b1;
                                end else begin
                                    n_pend_block = w_tail_blk;
                                    n_cmd1.kind  = emrd_pkg::K_WSB;
                                    n_cmd1.ent.ext_first = r_b + 32'd1;
                                    n_cmd1.ent.ext_block = w_trim_blk;
                                    fin = 1'b1;
                                    if (r_eq) begin
                                        n_cmd2.kind     = emrd_pkg::K_WSB;
                                        n_cmd2.tgt_prev = 1'b1;
                                        n_cmd2.ent.ext_first = r_s;
                                        n_cmd2.ent.ext_block = r_k;
                                    end else begin
                                        n_cmd2.kind = emrd_pkg::K_INS;
                                        n_cmd2.ent  = '{ext_first: r_s,
                                                        ext_last: r_a - 32'd1,
                                                        ext_block: r_k};
                                    end
                                end
                                n_next  = (fin || (n_n == RW'(emrd_pkg::MAX_RESULTS)))
                                          ? S_FLUSH : S_FIND;
                                n_state = S_U1;
                            end
                        end
                        default: begin
                            n_out_word.status = emrd_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            S_U1: begin
                if (r_cmd1.kind == emrd_pkg::K_INS) n_count = r_count + CW'(1);
                else if (r_cmd1.kind == emrd_pkg::K_DEL) n_count = r_count - CW'(1);
                n_state = S_U2;
            end
            S_U2: begin
                if (r_cmd2.kind == emrd_pkg::K_INS) n_count = r_count + CW'(1);
                else if (r_cmd2.kind == emrd_pkg::K_DEL) n_count = r_count - CW'(1);
                n_state = r_next;
            end
            S_FLUSH: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_word  = '0;
                    n_out_word.status       = r_pend_status;
                    n_out_word.freed_block  = r_pend_block;
                    n_out_word.freed_length = r_pend_len;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next      <= S_IDLE;
            r_count     <= '0;
            r_pend_v    <= 1'b0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
            r_cmd1      <= '0;
            r_cmd2      <= '0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_count     <= n_count;
            r_pend_v    <= n_pend_v;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
            r_cmd1      <= n_cmd1;
            r_cmd2      <= n_cmd2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_a           <= n_a;
        r_b           <= n_b;
        r_blk         <= n_blk;
        r_s           <= n_s;
        r_e           <= n_e;
        r_k           <= n_k;
        r_hit         <= n_hit;
        r_eq          <= n_eq;
        r_pend_status <= n_pend_status;
        r_pend_block  <= n_pend_block;
        r_pend_len    <= n_pend_len;
        r_out_word    <= n_out_word;
        r_out_last    <= n_out_last;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_word};
    assign o_m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EXTENTS))
        else $error("extent count above table size");

    a_ins_room1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_U1 && r_cmd1.kind == emrd_pkg::K_INS) |-> !w_full)
        else $error("slot opened in a full table");

    a_ins_room2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_U2 && r_cmd2.kind == emrd_pkg::K_INS) |-> !w_full)
        else $error("slot opened in a full table");

    a_res_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RW'(emrd_pkg::MAX_RESULTS))
        else $error("delete result count above limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out_word)))
        else $error("pending output word overwritten");
`endif

endmodule

// ----- test/emrd_checker.sv -----
// Checker for the extent map range delete unit: watches both stream channels,
// predicts result words from accepted commands and compares them in order.
// Depends on emrd_pkg.
`timescale 1ns / 1ps

module emrd_checker #(
    parameter int MAX_EXTENTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [103:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [167:0] i_m_tdata,
    input  logic         i_m_tlast,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct {
        logic [1:0]  status;
        logic [31:0] found_start;
        logic [31:0] found_end;
        logic [31:0] found_block;
        logic [31:0] freed_block;
        logic [32:0] freed_length;
        logic        last;
    } t_word;

    logic [31:0] tbl_first [MAX_EXTENTS];
    logic [31:0] tbl_last  [MAX_EXTENTS];
    logic [31:0] tbl_block [MAX_EXTENTS];
    int          tbl_count;
    t_word       want_q[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = want_q.size();

    function automatic int first_ending_at(logic [31:0] off);
        int i;
        i = 0;
        while (i < tbl_count && tbl_last[i] < off) i++;
        return i;
    endfunction

    function automatic void drop_entry(int i);
        for (int j = i; j < tbl_count - 1; j++) begin
            tbl_first[j] = tbl_first[j+1];
            tbl_last[j]  = tbl_last[j+1];
            tbl_block[j] = tbl_block[j+1];
        end
        tbl_count--;
    endfunction

    function automatic bit room_for(logic [31:0] e);
        int p;
        p = first_ending_at(e);
        if (p < tbl_count && tbl_last[p] == e) return 1;
        return tbl_count < MAX_EXTENTS;
    endfunction

    function automatic bit store_extent(logic [31:0] s, logic [31:0] e, logic [31:0] b);
        int p;
        p = first_ending_at(e);
        if (p < tbl_count && tbl_last[p] == e) begin
            tbl_first[p] = s;
            tbl_block[p] = b;
            return 1;
        end
        if (tbl_count >= MAX_EXTENTS) return 0;
        for (int j = tbl_count; j > p; j--) begin
            tbl_first[j] = tbl_first[j-1];
            tbl_last[j]  = tbl_last[j-1];
            tbl_block[j] = tbl_block[j-1];
        end
        tbl_first[p] = s;
        tbl_last[p]  = e;
        tbl_block[p] = b;
        tbl_count++;
        return 1;
    endfunction

    function automatic void push_word(logic [1:0] st, logic [31:0] fs, logic [31:0] fe,
                                      logic [31:0] fb, logic [31:0] blk, logic [32:0] len);
        t_word w;
        w.status = st; w.found_start = fs; w.found_end = fe; w.found_block = fb;
        w.freed_block = blk; w.freed_length = len; w.last = 0;
        want_q.push_back(w);
    endfunction

    function automatic void predict_command(logic [103:0] d);
        logic [1:0]  cmd;
        logic [31:0] a, b, blk, s, e, k, ms, me;
        logic [32:0] len;
        int          n, i;
        bit          ok;
        cmd = d[1:0]; a = d[33:2]; b = d[65:34]; blk = d[97:66];
        n = 0;
        case (cmd)
            emrd_pkg::CMD_SEARCH: begin
                i = first_ending_at(a);
                if (i >= tbl_count) push_word(emrd_pkg::ST_NONE, 0, 0, 0, 0, 0);
                else push_word((a >= tbl_first[i]) ? emrd_pkg::ST_OK : emrd_pkg::ST_MISS,
                               tbl_first[i], tbl_last[i], tbl_block[i], 0, 0);
                n = 1;
            end
            emrd_pkg::CMD_INSERT: begin
                if (a <= b) begin
                    ok = store_extent(a, b, blk);
                    push_word(ok ? emrd_pkg::ST_OK : emrd_pkg::ST_FULL, 0, 0, 0, 0, 0);
                end else push_word(emrd_pkg::ST_MISS, 0, 0, 0, 0, 0);
                n = 1;
            end
            emrd_pkg::CMD_DELETE: begin
                if (a <= b) begin
                    while (n < emrd_pkg::MAX_RESULTS) begin
                        i = first_ending_at(a);
                        if (i >= tbl_count || tbl_first[i] > b) break;
                        s = tbl_first[i]; e = tbl_last[i]; k = tbl_block[i];
                        ms = (a > s) ? a : s;
                        me = (b < e) ? b : e;
                        len = {1'b0, me} - {1'b0, ms} + 33'd1;
                        if (ms == s && me == e) begin
                            drop_entry(i);
                            push_word(emrd_pkg::ST_OK, 0, 0, 0, k, len);
                        end else if (ms == s) begin
                            tbl_first[i] = me + 1;
                            tbl_block[i] = k + len[31:0];
                            push_word(emrd_pkg::ST_OK, 0, 0, 0, k, len);
                        end else if (me == e) begin
                            drop_entry(i);
                            ok = store_extent(s, ms - 1, k);
                            push_word(emrd_pkg::ST_OK, 0, 0, 0, k + (ms - s), len);
                        end else begin
                            if (!room_for(ms - 1)) begin
                                push_word(emrd_pkg::ST_FULL, 0, 0, 0, 0, 0);
                                n++;
                                break;
                            end
                            tbl_first[i] = me + 1;
                            tbl_block[i] = k + (me - s + 1);
                            ok = store_extent(s, ms - 1, k);
                            push_word(emrd_pkg::ST_OK, 0, 0, 0, k + (ms - s), len);
                        end
                        n++;
                    end
                end
                if (n == 0) begin
                    push_word(emrd_pkg::ST_MISS, 0, 0, 0, 0, 0);
                    n = 1;
                end
            end
            default: begin
                push_word(emrd_pkg::ST_MISS, 0, 0, 0, 0, 0);
                n = 1;
            end
        endcase
        want_q[$].last = 1;
    endfunction

    task automatic compare_word(input logic [167:0] d, input logic lst);
        t_word w;
        if (want_q.size() == 0) begin
            $error("unexpected result word %h", d);
            fails++;
            return;
        end
        w = want_q.pop_front();
        if (d[1:0] !== w.status) begin
            $error("status exp %0d got %0d", w.status, d[1:0]); fails++;
        end
        if (d[33:2] !== w.found_start) begin
            $error("found_start exp %h got %h", w.found_start, d[33:2]); fails++;
        end
        if (d[65:34] !== w.found_end) begin
            $error("found_end exp %h got %h", w.found_end, d[65:34]); fails++;
        end
        if (d[97:66] !== w.found_block) begin
            $error("found_block exp %h got %h", w.found_block, d[97:66]); fails++;
        end
        if (d[129:98] !== w.freed_block) begin
            $error("freed_block exp %h got %h", w.freed_block, d[129:98]); fails++;
        end
        if (d[162:130] !== w.freed_length) begin
            $error("freed_length exp %h got %h", w.freed_length, d[162:130]); fails++;
        end
        if (lst !== w.last) begin
            $error("last exp %0b got %0b", w.last, lst); fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tbl_count = 0;
        end else begin
            // result compared first: a new command's words can't come out this edge
            if (i_m_tvalid && i_m_tready) compare_word(i_m_tdata, i_m_tlast);
            if (i_s_tvalid && i_s_tready) predict_command(i_s_tdata);
        end
    end

    initial fails = 0;
endmodule

// ----- test/tb_extent_map_range_delete_unit.sv -----
// Testbench top for the extent map range delete unit: drives command words
// with random gaps and back-pressure; emrd_checker predicts and compares.
// Depends on emrd_pkg, emrd_checker and the unit itself.
`timescale 1ns / 1ps

module tb_extent_map_range_delete_unit;

    localparam int N_RANDOM    = 170;
    localparam int CYCLE_LIMIT = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;
    logic         m_tlast;
    int           fail_count;
    int           pending;
    int           cycles;
    bit           calm;     // no stalls in the last part

    extent_map_range_delete_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    emrd_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver back-pressure in bursts
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 5);
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else m_tready = 1'b1;
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] blk);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  = {6'd0, blk, b, a, cmd};
        s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] small_off();
        return $urandom_range(0, 255);
    endfunction

    initial begin
        logic [31:0] a, b;
        int          r;
        cycles   = 0;
        calm     = 0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, extremes, inverted ranges, splits, unused command
        send_word(emrd_pkg::CMD_SEARCH, 32'd0, 32'd0, 32'd0);
        send_word(emrd_pkg::CMD_DELETE, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_word(emrd_pkg::CMD_INSERT, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_word(emrd_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_word(emrd_pkg::CMD_DELETE, 32'd100, 32'd199, 32'd0);
        send_word(emrd_pkg::CMD_DELETE, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_word(emrd_pkg::CMD_INSERT, 32'd10, 32'd5, 32'd1);
        send_word(emrd_pkg::CMD_DELETE, 32'd10, 32'd5, 32'd1);
        send_word(emrd_pkg::CMD_INSERT, 32'd10, 32'd20, 32'd1000);
        send_word(emrd_pkg::CMD_INSERT, 32'd12, 32'd20, 32'd2000);
        send_word(emrd_pkg::CMD_INSERT, 32'd30, 32'd40, 32'd3000);
        send_word(emrd_pkg::CMD_SEARCH, 32'd5, 32'd0, 32'd0);
        send_word(emrd_pkg::CMD_SEARCH, 32'd25, 32'd0, 32'd0);
        send_word(emrd_pkg::CMD_SEARCH, 32'd41, 32'd0, 32'd0);
        send_word(emrd_pkg::CMD_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(emrd_pkg::CMD_DELETE, 32'd15, 32'd35, 32'd0);
        send_word(emrd_pkg::CMD_DELETE, 32'd50, 32'd60, 32'd0);
        // fill the table, then force a split with no room
        for (int i = 0; i < 33; i++)
            send_word(emrd_pkg::CMD_INSERT, 32'd1000 + 10 * i, 32'd1005 + 10 * i, $urandom);
        send_word(emrd_pkg::CMD_DELETE, 32'd1001, 32'd1002, 32'd0);
        send_word(emrd_pkg::CMD_DELETE, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_word(emrd_pkg::CMD_DELETE, 32'd0, 32'hFFFF_FFFF, 32'd0);

        // random: mostly small offsets so extents meet, a few full-range values
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM - 30) calm = 1;
            r = $urandom_range(0, 9);
            if ($urandom_range(0, 9) == 0) begin
                a = $urandom; b = $urandom;
            end else begin
                a = small_off(); b = a + $urandom_range(0, 40);
                if ($urandom_range(0, 15) == 0) b = a - 1;
            end
            if (r < 5) send_word(emrd_pkg::CMD_INSERT, a, b, $urandom);
            else if (r < 7) send_word(emrd_pkg::CMD_SEARCH, a, $urandom, $urandom);
            else if (r < 9) send_word(emrd_pkg::CMD_DELETE, a, b, $urandom);
            else send_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end

        calm = 1;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/emrd_pkg.sv
hdl/emrd_cell.sv
hdl/extent_map_range_delete_unit.sv
test/emrd_checker.sv
test/tb_extent_map_range_delete_unit.sv
